>>> rtl/mmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmac_pkg
// Types, codes and address map constants shared by the memory map access
// checker modules.
// ----------------------------------------------------------------------------
package mmac_pkg;

  // Default sizes of the decoded regions and the watch limit.
  localparam int unsigned RAM_BYTES_DEF    = 65536;
  localparam int unsigned ROM_BYTES_DEF    = 4194304;
  localparam int unsigned SHARED_BYTES_DEF = 1048576;
  localparam int unsigned MAX_WATCHES_DEF  = 2;

  localparam int ADDR_W   = 24;
  localparam int SIZE_W   = 16;
  localparam int OFFS_W   = 22;
  localparam int MASK_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // Address map.
  localparam logic [ADDR_W-1:0] RAM_BASE    = 24'hff0000;
  localparam logic [ADDR_W-1:0] ROM_END     = 24'h400000;
  localparam logic [ADDR_W-1:0] SHARED_BASE = 24'h800000;
  localparam logic [ADDR_W-1:0] SHARED_END  = 24'h900000;
  localparam logic [ADDR_W-1:0] DUMMY_BASE  = 24'ha00000;
  localparam logic [ADDR_W-1:0] DUMMY_END   = 24'hd00000;
  localparam logic [16:0]       BLOCK_BYTES = 17'h04000;

  // Command codes.
  localparam logic [2:0] CMD_READ        = 3'd0;
  localparam logic [2:0] CMD_WRITE       = 3'd1;
  localparam logic [2:0] CMD_WRITE_WATCH = 3'd2;
  localparam logic [2:0] CMD_QUERY_READ  = 3'd3;
  localparam logic [2:0] CMD_QUERY_WRITE = 3'd4;
  localparam logic [2:0] CMD_CLEAR_USAGE = 3'd5;

  // Region codes.
  localparam logic [2:0] REG_RAM     = 3'd0;
  localparam logic [2:0] REG_ROM     = 3'd1;
  localparam logic [2:0] REG_SHARED  = 3'd2;
  localparam logic [2:0] REG_DUMMY   = 3'd3;
  localparam logic [2:0] REG_INVALID = 3'd4;

  // Outcome codes.
  localparam logic [1:0] OUT_OK        = 2'd0;
  localparam logic [1:0] OUT_NO_DIRECT = 2'd1;
  localparam logic [1:0] OUT_TOO_LARGE = 2'd2;
  localparam logic [1:0] OUT_INVALID   = 2'd3;

  // Result kinds.
  localparam logic KIND_FINAL = 1'b0;
  localparam logic KIND_HIT   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH0_ADDR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH0_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH1_ADDR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCH1_BYTES  = 3'd5;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [2:0]        region;
    logic [1:0]        outcome;
    logic [OFFS_W-1:0] offset;
    logic              watch_index;
    logic [MASK_W-1:0] usage_mask;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              notify_enable;
    logic [1:0]        watch_count;
    logic [ADDR_W-1:0] watch0_address;
    logic [SIZE_W-1:0] watch0_bytes;
    logic [ADDR_W-1:0] watch1_address;
    logic [SIZE_W-1:0] watch1_bytes;
  } watch_cfg_t;

  // Everything the result sequencer needs for one decoded transaction.
  typedef struct packed {
    logic              emit;
    logic [1:0]        hits;
    logic [2:0]        region;
    logic [1:0]        outcome;
    logic [OFFS_W-1:0] offset;
    logic [MASK_W-1:0] mask_before;
    logic [MASK_W-1:0] mask_after;
  } bundle_t;

endpackage

>>> rtl/mmac_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmac_decode
// Region decode, bounds check, watch overlap test and shared memory usage
// update for one registered request.
// ----------------------------------------------------------------------------
module mmac_decode #(
  parameter int unsigned RAM_BYTES    = mmac_pkg::RAM_BYTES_DEF,
  parameter int unsigned ROM_BYTES    = mmac_pkg::ROM_BYTES_DEF,
  parameter int unsigned SHARED_BYTES = mmac_pkg::SHARED_BYTES_DEF,
  parameter int unsigned MAX_WATCHES  = mmac_pkg::MAX_WATCHES_DEF
) (
  input  mmac_pkg::in_item_t                 item,
  input  mmac_pkg::watch_cfg_t               wcfg,
  input  logic [mmac_pkg::MASK_W-1:0]        usage,
  output mmac_pkg::bundle_t                  bundle
);
  import mmac_pkg::*;

  localparam logic [OFFS_W:0] RAM_LIM    = (OFFS_W+1)'(RAM_BYTES);
  localparam logic [OFFS_W:0] ROM_LIM    = (OFFS_W+1)'(ROM_BYTES);
  localparam logic [OFFS_W:0] SHARED_LIM = (OFFS_W+1)'(SHARED_BYTES);
  localparam logic [1:0]      MAXW       = 2'(MAX_WATCHES);

  logic [2:0]        region;
  logic [OFFS_W-1:0] offset;
  logic [OFFS_W:0]   limit;
  logic [OFFS_W:0]   end_offs;
  logic              fits;
  logic [ADDR_W:0]   acc_end;
  logic [ADDR_W:0]   w0_end;
  logic [ADDR_W:0]   w1_end;
  logic [1:0]        wcount;
  logic              watch_on;
  logic [1:0]        hits;
  logic [1:0]        outcome;
  logic [16:0]       blk_end;
  logic [5:0]        blk;
  logic [MASK_W-1:0] set_bits;
  logic              mark;

  always_comb begin
    offset = '0;
    limit  = '0;
    if (item.address >= RAM_BASE) begin
      region = REG_RAM;
      offset = {6'd0, item.address[15:0]};
      limit  = RAM_LIM;
    end else if (item.address < ROM_END) begin
      region = REG_ROM;
      offset = item.address[OFFS_W-1:0];
      limit  = ROM_LIM;
    end else if (item.address >= SHARED_BASE && item.address < SHARED_END) begin
      region = REG_SHARED;
      offset = {2'd0, item.address[19:0]};
      limit  = SHARED_LIM;
    end else if (item.address >= DUMMY_BASE && item.address < DUMMY_END) begin
      region = REG_DUMMY;
    end else begin
      region = REG_INVALID;
    end
  end

  assign end_offs = {1'b0, offset} + {{(OFFS_W+1-SIZE_W){1'b0}}, item.size};
  assign fits     = end_offs <= limit;

  // Watches are tested on the full bus address, before the bounds check.
  assign acc_end  = {1'b0, item.address} + {{(ADDR_W+1-SIZE_W){1'b0}}, item.size};
  assign w0_end   = {1'b0, wcfg.watch0_address} +
                    {{(ADDR_W+1-SIZE_W){1'b0}}, wcfg.watch0_bytes};
  assign w1_end   = {1'b0, wcfg.watch1_address} +
                    {{(ADDR_W+1-SIZE_W){1'b0}}, wcfg.watch1_bytes};
  assign wcount   = (wcfg.watch_count > MAXW) ? MAXW : wcfg.watch_count;
  assign watch_on = (item.cmd == CMD_WRITE_WATCH) && wcfg.notify_enable &&
                    (region == REG_RAM || region == REG_SHARED);

  assign hits[0] = watch_on && (wcount > 2'd0) &&
                   (acc_end > {1'b0, wcfg.watch0_address}) &&
                   ({1'b0, item.address} < w0_end);
  assign hits[1] = watch_on && (wcount > 2'd1) &&
                   (acc_end > {1'b0, wcfg.watch1_address}) &&
                   ({1'b0, item.address} < w1_end);

  // A write crossing a block end marks the following block too.
  assign blk      = offset[19:14];
  assign blk_end  = {3'd0, offset[13:0]} + {1'b0, item.size};
  assign set_bits = (blk_end <= BLOCK_BYTES) ? (MASK_W'(1) << blk) : (MASK_W'(3) << blk);

  always_comb begin
    mark = 1'b0;
    if (region == REG_INVALID) begin
      outcome = OUT_INVALID;
    end else if (region == REG_DUMMY) begin
      outcome = (item.cmd >= CMD_QUERY_READ) ? OUT_NO_DIRECT : OUT_OK;
    end else if (!fits) begin
      outcome = OUT_TOO_LARGE;
    end else if (item.cmd <= CMD_WRITE_WATCH) begin
      outcome = OUT_OK;
      mark    = (region == REG_SHARED) && (item.cmd != CMD_READ);
    end else begin
      outcome = (region == REG_SHARED && item.cmd == CMD_QUERY_WRITE) ?
                OUT_NO_DIRECT : OUT_OK;
    end
  end

  always_comb begin
    bundle.emit        = item.cmd <= CMD_CLEAR_USAGE;
    bundle.hits        = hits;
    bundle.region      = region;
    bundle.outcome     = outcome;
    bundle.offset      = offset;
    bundle.mask_before = usage;
    bundle.mask_after  = mark ? (usage | set_bits) : usage;
    if (item.cmd == CMD_CLEAR_USAGE) begin
      bundle.hits       = 2'b00;
      bundle.region     = REG_RAM;
      bundle.outcome    = OUT_OK;
      bundle.offset     = '0;
      bundle.mask_after = '0;
    end
  end

endmodule

>>> rtl/mmac_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmac_emit
// Result register and sequencer: presents the watch hit events of a
// transaction in watch order, then its final result.
// ----------------------------------------------------------------------------
module mmac_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  mmac_pkg::bundle_t   bundle,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_stall,
  output mmac_pkg::out_item_t out_data
);
  import mmac_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [1:0] pend_r;
  logic [1:0] pend_nxt;
  bundle_t    b_r;
  logic       take;
  logic       is_last;

  assign is_last = pend_r == 2'b00;
  assign take    = valid_r && !out_stall;
  assign ready   = !valid_r || (take && is_last);

  always_comb begin
    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    if (load) begin
      valid_nxt = 1'b1;
      pend_nxt  = bundle.hits;
    end else if (take) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else if (pend_r[0]) begin
        pend_nxt = {pend_r[1], 1'b0};
      end else begin
        pend_nxt = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 2'b00;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_r <= bundle;
    end
  end

  always_comb begin
    out_data.region = b_r.region;
    out_data.offset = b_r.offset;
    if (is_last) begin
      out_data.kind        = KIND_FINAL;
      out_data.outcome     = b_r.outcome;
      out_data.watch_index = 1'b0;
      out_data.usage_mask  = b_r.mask_after;
      out_data.last        = 1'b1;
    end else begin
      out_data.kind        = KIND_HIT;
      out_data.outcome     = OUT_OK;
      out_data.watch_index = !pend_r[0];
      out_data.usage_mask  = b_r.mask_before;
      out_data.last        = 1'b0;
    end
  end

  assign out_valid = valid_r;

  // A new transaction only enters once the previous final result leaves.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!valid_r || (take && is_last)))
    else $error("result register overwritten");

  // Hit events are never final, and final results are always marked last.
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind != out_data.last))
    else $error("kind and last disagree");

  a_hit_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_HIT) |->
      (out_data.region == REG_RAM || out_data.region == REG_SHARED))
    else $error("watch hit outside RAM or shared memory");

  // After a hit event is taken, the sequencer never falls back to an earlier watch.
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_last && out_data.watch_index) |=> (valid_r && is_last))
    else $error("watch hit events out of order");

endmodule

>>> rtl/memory_map_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_map_access_checker
// Decodes bus access requests into RAM, ROM, shared memory, dummy I/O or
// invalid space, checks bounds, tracks shared memory block usage and reports
// watch hits.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | in_data   (cmd, address, size)
//   out_    | output    | out_valid/out_stall| out_data  (result or watch hit)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A request is registered, decoded combinationally from that register and moved
// into the result register, from which its results are presented: one hit
// event for each watch hit, in watch order, then the final result. One
// request per cycle is taken when each yields a single result and out_stall
// is low; a write with watch hits holds the result register until all of
// its results have been taken, and further requests wait meanwhile. Commands
// six and seven produce no result. Reset is synchronous and clears the usage
// mask and configuration. cfg_ready is always high.
// ----------------------------------------------------------------------------
module memory_map_access_checker #(
  parameter int unsigned RAM_BYTES    = mmac_pkg::RAM_BYTES_DEF,
  parameter int unsigned ROM_BYTES    = mmac_pkg::ROM_BYTES_DEF,
  parameter int unsigned SHARED_BYTES = mmac_pkg::SHARED_BYTES_DEF,
  parameter int unsigned MAX_WATCHES  = mmac_pkg::MAX_WATCHES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mmac_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mmac_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mmac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmac_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mmac_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  in_item_t          s1_item_r;
  watch_cfg_t        wcfg_r;
  logic [MASK_W-1:0] usage_r;
  logic [MASK_W-1:0] usage_nxt;
  bundle_t           bundle;
  logic              em_ready;
  logic              em_load;
  logic              in_take;
  logic              advance;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_valid_r && !em_ready;
  assign in_take   = in_valid && !in_stall;
  assign advance   = s1_valid_r && em_ready;
  assign em_load   = advance && bundle.emit;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  // The usage mask changes when a transaction moves to the result register.
  assign usage_nxt = advance ? bundle.mask_after : usage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usage_r <= '0;
    end else begin
      usage_r <= usage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NOTIFY_ENABLE: wcfg_r.notify_enable  <= cfg_data[0];
        CFG_WATCH_COUNT:   wcfg_r.watch_count    <= cfg_data[1:0];
        CFG_WATCH0_ADDR:   wcfg_r.watch0_address <= cfg_data[ADDR_W-1:0];
        CFG_WATCH0_BYTES:  wcfg_r.watch0_bytes   <= cfg_data[SIZE_W-1:0];
        CFG_WATCH1_ADDR:   wcfg_r.watch1_address <= cfg_data[ADDR_W-1:0];
        CFG_WATCH1_BYTES:  wcfg_r.watch1_bytes   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  mmac_decode #(
    .RAM_BYTES    (RAM_BYTES),
    .ROM_BYTES    (ROM_BYTES),
    .SHARED_BYTES (SHARED_BYTES),
    .MAX_WATCHES  (MAX_WATCHES)
  ) u_decode (
    .item   (s1_item_r),
    .wcfg   (wcfg_r),
    .usage  (usage_r),
    .bundle (bundle)
  );

  mmac_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (em_load),
    .bundle    (bundle),
    .ready     (em_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
